### sv/skpn_pkg.sv
package skpn_pkg;

  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned KEY_BITS   = 64;
  localparam int unsigned PTR_BITS   = 64;
  localparam int unsigned FIELD_BITS = 64;
  localparam int unsigned CNT_BITS   = $clog2(CAPACITY + 1);

  typedef enum logic {
    FUNC_SEARCH = 1'b0,
    FUNC_INSERT = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_DUP  = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  typedef enum logic {
    CFG_PAGE_MODE = 1'b0,
    CFG_LEFTMOST  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_e;

  typedef struct packed {
    logic                  func;
    logic [FIELD_BITS-1:0] search_key;
    logic [FIELD_BITS-1:0] new_pointer;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] child_pointer;
    logic [1:0]            status;
    logic                  now_full;
  } out_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [PTR_BITS-1:0] ptr;
    logic                eq;
    logic                keep;
  } cell_link_t;

  typedef struct packed {
    logic cmp_en;
    logic upd_en;
    logic sec_eq;
  } cell_ctrl_t;

endpackage

### sv/sorted_key_pointer_node_top.sv
// Each accepted item passes a compare state in every cell of the chain and then an
// update state that selects and shifts the row; its result beat is then registered.
// A new item is accepted in the update state of the last one, as that item finishes.
// A stalled result holds the update cycle until the output register frees up.
// Reset clears the entry count, the configuration and the handshake state.
module sorted_key_pointer_node_top import skpn_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [0:0]            cfg_index_i,
  input  logic [FIELD_BITS-1:0] cfg_wdata_i
);

  state_e                state_q, state_d;
  in_item_t              in_q;
  logic [CNT_BITS-1:0]   count_q, count_d;
  logic                  page_mode_q;
  logic [PTR_BITS-1:0]   leftmost_q;
  logic                  out_valid_q;
  out_item_t             out_q, out_d;

  cell_ctrl_t            ctrl;
  cell_link_t            chain [CAPACITY+1];
  logic [CAPACITY:0]     keep_v;
  logic [CAPACITY-1:0]   eq_v;
  logic [CAPACITY-1:0]   occ;
  logic [PTR_BITS-1:0]   sel_ptr [CAPACITY];
  logic [PTR_BITS-1:0]   sel_or;
  logic [PTR_BITS-1:0]   child_sel;
  logic [KEY_BITS-1:0]   key_in;
  logic [PTR_BITS-1:0]   ptr_in;
  logic                  any_eq;
  logic                  full;
  logic                  can_finish;
  logic                  finish;
  logic                  do_ins;
  logic                  in_acc;
  status_e               status;

  assign key_in     = in_q.search_key[KEY_BITS-1:0];
  assign ptr_in     = in_q.new_pointer[PTR_BITS-1:0];
  assign any_eq     = |eq_v;
  assign full       = (count_q == CNT_BITS'(CAPACITY));
  assign can_finish = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) || ((state_q == S_UPD) && can_finish));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d     = state_q;
    finish      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_CMP;
      end
      S_CMP: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (can_finish) begin
          finish  = 1'b1;
          state_d = in_acc ? S_CMP : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_item_i;
    end
  end

  always_comb begin
    sel_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_or = sel_or | sel_ptr[i];
    end
  end

  assign child_sel = keep_v[0] ? sel_or : leftmost_q;

  always_comb begin
    do_ins = 1'b0;
    status = STATUS_OK;
    if (in_q.func == FUNC_INSERT) begin
      if (full) begin
        status = STATUS_FULL;
      end else if (!page_mode_q && any_eq) begin
        status = STATUS_DUP;
      end else begin
        do_ins = 1'b1;
      end
    end
    count_d = count_q + CNT_BITS'(finish && do_ins);
    out_d.child_pointer = (in_q.func == FUNC_INSERT) ? '0 : FIELD_BITS'(child_sel);
    out_d.status        = status;
    out_d.now_full      = (count_d == CNT_BITS'(CAPACITY));
  end

  assign ctrl = '{cmp_en: (state_q == S_CMP),
                  upd_en: (finish && do_ins),
                  sec_eq: (page_mode_q && any_eq)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
      page_mode_q <= 1'b0;
      leftmost_q  <= '0;
    end else begin
      count_q <= count_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_PAGE_MODE: page_mode_q <= cfg_wdata_i[0];
          CFG_LEFTMOST:  leftmost_q  <= cfg_wdata_i[PTR_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign chain[0] = '{key: '0, ptr: '0, eq: 1'b0, keep: 1'b1};
  assign keep_v[CAPACITY] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNT_BITS-1:0] Idx = CNT_BITS'(i);

    assign occ[i]    = (Idx < count_q);
    assign keep_v[i] = chain[i+1].keep;

    skpn_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .occ_i       (occ[i]),
      .key_i       (key_in),
      .ptr_i       (ptr_in),
      .prev_i      (chain[i]),
      .next_keep_i (keep_v[i+1]),
      .link_o      (chain[i+1]),
      .eq_o        (eq_v[i]),
      .sel_ptr_o   (sel_ptr[i])
    );
  end

endmodule

### sv/skpn_cell.sv
module skpn_cell import skpn_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_ctrl_t          ctrl_i,
  input  logic                occ_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic [PTR_BITS-1:0] ptr_i,
  input  cell_link_t          prev_i,
  input  logic                next_keep_i,
  output cell_link_t          link_o,
  output logic                eq_o,
  output logic [PTR_BITS-1:0] sel_ptr_o
);

  logic [KEY_BITS-1:0] key_q, key_d;
  logic [PTR_BITS-1:0] ptr_q, ptr_d;
  logic                le_q, lt_q, eq_q;
  logic                first_eq;
  logic                keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      le_q <= 1'b0;
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      le_q <= occ_i && (key_q <= key_i);
      lt_q <= occ_i && (key_q < key_i);
      eq_q <= occ_i && (key_q == key_i);
    end
  end

  // A cell keeps its entry when it lies at or below the located position;
  // the first cell past that position takes the new pair, the rest shift up.
  always_comb begin
    first_eq = eq_q && !prev_i.eq;
    keep     = ctrl_i.sec_eq ? (lt_q || first_eq) : le_q;
    key_d    = key_q;
    ptr_d    = ptr_q;
    if (ctrl_i.upd_en && !keep) begin
      if (prev_i.keep) begin
        key_d = key_i;
        ptr_d = ptr_i;
      end else begin
        key_d = prev_i.key;
        ptr_d = prev_i.ptr;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    ptr_q <= ptr_d;
  end

  assign link_o    = '{key: key_q, ptr: ptr_q, eq: eq_q, keep: keep};
  assign eq_o      = eq_q;
  assign sel_ptr_o = (keep && !next_keep_i) ? ptr_q : '0;

endmodule

### sv/skpn_checker.sv
module skpn_checker import skpn_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // An accepted beat keeps the input side busy during its compare state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken during the compare cycle");

  // A result beat only appears after a busy cycle on the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o, 2))
    else $error("result beat without a compare cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.status == STATUS_OK || out_item_o.status == STATUS_DUP ||
                     out_item_o.status == STATUS_FULL))
    else $error("undefined status code");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result beat changed");

endmodule

bind sorted_key_pointer_node_top skpn_checker u_skpn_checker (.*);
